[rtl/tlbl_pkg.sv]
// ----------------------------------------------------------------------------
// tlbl_pkg: shared types and constants for the LCA binary-lifting block
// Holds the node and depth widths, the table geometry, the opcode codes and
// the helper that maps a raw node field onto a table row.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbl_pkg;

  // Fixed widths of the interface fields.
  localparam int FIELD_W = 10;
  localparam int DEP_W   = 10;
  localparam logic [DEP_W-1:0] DEPTH_MAX = '1;

  // Table geometry. MAX_NODES is a power of two.
  localparam int MAX_NODES   = 1024;
  localparam int LIFT_LEVELS = 10;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int LVL_W       = $clog2(LIFT_LEVELS);
  localparam int ANC_DEPTH   = LIFT_LEVELS * MAX_NODES;
  localparam int ANC_AW      = LVL_W + NODE_W;

  // Width of the lifting compare: depth plus the largest step.
  localparam int CMP_W = ((DEP_W > LIFT_LEVELS) ? DEP_W : LIFT_LEVELS) + 1;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEP_W-1:0]   dep_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [FIELD_W-1:0] field_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  // A node number at or beyond the table is treated as the virtual node 0.
  function automatic node_t node_index(input field_t raw);
    node_t res;
    res = '0;
    if (32'(raw) < MAX_NODES) begin
      res = node_t'(raw);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/tlbl_ram.sv]
// ----------------------------------------------------------------------------
// tlbl_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/tree_lca_binary_lifting_top.sv]
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting_top: lowest common ancestor by binary lifting
// Keeps a rooted tree as a depth table and a level-by-node ancestor table,
// both in RAM, and walks them with one small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Transfer when
//  -------   ----------------------------------------  ----------------------
//  command   start, busy, opcode_i, node_a_i, node_b_i start high, busy low
//  result    result_valid_o, ancestor_o                result_valid_o high
//  config    cfg_valid_i, cfg_ready_o, cfg_data_i      valid and ready high
//
// A load reads the parent's depth and then writes the node's row. A query reads
// both depths, lifts the deeper node, then raises both nodes together; a build
// walks levels 1 up to LIFT_LEVELS - 1 over nodes 1 through last, where last is
// node_count limited to the table. Each RAM has one read port, read data registered.
// Reset idles the sequencer, drops the strobe, sets node_count to 1023; RAMs are not cleared.
// The result strobe is high for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_lca_binary_lifting_top (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              opcode_i,
  input  wire logic [tlbl_pkg::FIELD_W-1:0] node_a_i,
  input  wire logic [tlbl_pkg::FIELD_W-1:0] node_b_i,
  output logic                         result_valid_o,
  output logic [tlbl_pkg::FIELD_W-1:0] ancestor_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [tlbl_pkg::FIELD_W-1:0] cfg_data_i
);

  import tlbl_pkg::*;

  // Sequencer states, one-hot.
  typedef enum logic [16:0] {
    S_IDLE   = 17'b00000000000000001,
    S_LD_RD  = 17'b00000000000000010,
    S_LD_WR  = 17'b00000000000000100,
    S_B_RD1  = 17'b00000000000001000,
    S_B_RD2  = 17'b00000000000010000,
    S_B_WR   = 17'b00000000000100000,
    S_Q_DA   = 17'b00000000001000000,
    S_Q_DB   = 17'b00000000010000000,
    S_Q_SW   = 17'b00000000100000000,
    S_Q_L1   = 17'b00000001000000000,
    S_Q_L1A  = 17'b00000010000000000,
    S_Q_L1D  = 17'b00000100000000000,
    S_Q_EQ   = 17'b00001000000000000,
    S_Q_P2A  = 17'b00010000000000000,
    S_Q_P2B  = 17'b00100000000000000,
    S_Q_P2C  = 17'b01000000000000000,
    S_Q_FIN  = 17'b10000000000000000
  } state_e;

  state_e state_q, state_d;

  // Working registers: the two walking nodes, their depths, a held
  // ancestor, the level and node counters.
  node_t  a_q, a_d, b_q, b_d, x_q, x_d, j_q, j_d;
  dep_t   da_q, da_d, db_q, db_d;
  lvl_t   lvl_q, lvl_d;
  field_t node_count_q, node_count_d;
  logic   res_valid_q, res_valid_d;
  field_t res_q, res_d;

  // Depth RAM ports.
  logic  dep_we;
  node_t dep_waddr, dep_raddr, dep_rnode;
  dep_t  dep_wdata, dep_rdata, dep_val;
  logic  dep_rz_q;

  // Ancestor RAM ports. A row address is {level, node}.
  logic              anc_we;
  logic [ANC_AW-1:0] anc_waddr, anc_raddr;
  node_t             anc_wdata, anc_rdata, anc_val, anc_rnode;
  lvl_t              anc_rlvl;
  logic              anc_rz_q;

  node_t last;
  logic  lift_ok;
  node_t in_a, in_b;

  tlbl_ram #(.WIDTH(DEP_W), .DEPTH(MAX_NODES)) u_dep_ram (
    .clk_i   (clk_i),
    .we_i    (dep_we),
    .waddr_i (dep_waddr),
    .wdata_i (dep_wdata),
    .raddr_i (dep_raddr),
    .rdata_o (dep_rdata)
  );

  tlbl_ram #(.WIDTH(NODE_W), .DEPTH(ANC_DEPTH)) u_anc_ram (
    .clk_i   (clk_i),
    .we_i    (anc_we),
    .waddr_i (anc_waddr),
    .wdata_i (anc_wdata),
    .raddr_i (anc_raddr),
    .rdata_o (anc_rdata)
  );

  // Node 0 is never written; its depth and all its ancestors read as zero.
  // The flags remember whether the pending read addressed node 0.
  assign dep_raddr = dep_rnode;
  assign anc_raddr = {anc_rlvl, anc_rnode};
  assign dep_val   = dep_rz_q ? '0 : dep_rdata;
  assign anc_val   = anc_rz_q ? '0 : anc_rdata;

  assign in_a = node_index(node_a_i);
  assign in_b = node_index(node_b_i);

  // A build covers nodes 1 through node_count, bounded by the table size.
  assign last = (32'(node_count_q) > MAX_NODES - 1) ? node_t'(MAX_NODES - 1)
                                                   : node_t'(node_count_q);

  // The lifting compare: may node a climb 2^lvl levels and stay at or below b?
  assign lift_ok = CMP_W'(da_q) >= (CMP_W'(db_q) + (CMP_W'(1) << lvl_q));

  assign busy           = (state_q != S_IDLE);
  assign cfg_ready_o    = !busy;
  assign result_valid_o = res_valid_q;
  assign ancestor_o     = res_q;

  always_comb begin
    state_d      = state_q;
    a_d          = a_q;
    b_d          = b_q;
    x_d          = x_q;
    j_d          = j_q;
    da_d         = da_q;
    db_d         = db_q;
    lvl_d        = lvl_q;
    node_count_d = node_count_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;

    dep_we    = 1'b0;
    dep_waddr = a_q;
    dep_wdata = (dep_val == DEPTH_MAX) ? DEPTH_MAX : dep_val + 1'b1;
    dep_rnode = a_q;

    anc_we    = 1'b0;
    anc_waddr = {lvl_q, j_q};
    anc_wdata = anc_val;
    anc_rnode = a_q;
    anc_rlvl  = lvl_q;

    if (cfg_valid_i && cfg_ready_o) begin
      node_count_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          a_d = in_a;
          b_d = in_b;
          case (op_e'(opcode_i))
            OP_LOAD:  state_d = S_LD_RD;
            OP_BUILD: begin
              lvl_d = lvl_t'(1);
              j_d   = node_t'(1);
              if (last != '0) begin
                state_d = S_B_RD1;
              end
            end
            OP_QUERY: state_d = S_Q_DA;
            default:  state_d = S_IDLE;
          endcase
        end
      end

      // Load: fetch the parent's depth, then write the node's row.
      S_LD_RD: begin
        dep_rnode = b_q;
        state_d   = S_LD_WR;
      end
      S_LD_WR: begin
        if (a_q != '0) begin
          dep_we    = 1'b1;
          anc_we    = 1'b1;
          anc_waddr = {lvl_t'(0), a_q};
          anc_wdata = b_q;
        end
        state_d = S_IDLE;
      end

      // Build: table[lvl][j] = table[lvl-1][table[lvl-1][j]].
      S_B_RD1: begin
        anc_rnode = j_q;
        anc_rlvl  = lvl_t'(lvl_q - 1'b1);
        state_d   = S_B_RD2;
      end
      S_B_RD2: begin
        anc_rnode = anc_val;
        anc_rlvl  = lvl_t'(lvl_q - 1'b1);
        state_d   = S_B_WR;
      end
      S_B_WR: begin
        anc_we = 1'b1;
        if (j_q == last) begin
          j_d = node_t'(1);
          if (lvl_q == lvl_t'(LIFT_LEVELS - 1)) begin
            state_d = S_IDLE;
          end else begin
            lvl_d   = lvl_t'(lvl_q + 1'b1);
            state_d = S_B_RD1;
          end
        end else begin
          j_d     = node_t'(j_q + 1'b1);
          state_d = S_B_RD1;
        end
      end

      // Query: read both depths and make a the deeper node.
      S_Q_DA: begin
        dep_rnode = a_q;
        state_d   = S_Q_DB;
      end
      S_Q_DB: begin
        da_d      = dep_val;
        dep_rnode = b_q;
        state_d   = S_Q_SW;
      end
      S_Q_SW: begin
        if (da_q < dep_val) begin
          a_d  = b_q;
          b_d  = a_q;
          da_d = dep_val;
          db_d = da_q;
        end else begin
          db_d = dep_val;
        end
        lvl_d   = lvl_t'(LIFT_LEVELS - 1);
        state_d = S_Q_L1;
      end

      // Lift a toward b's depth, largest step first; the new depth is read
      // back from the table after each step.
      S_Q_L1: begin
        anc_rnode = a_q;
        if (lift_ok) begin
          state_d = S_Q_L1A;
        end else if (lvl_q == '0) begin
          state_d = S_Q_EQ;
        end else begin
          lvl_d = lvl_t'(lvl_q - 1'b1);
        end
      end
      S_Q_L1A: begin
        a_d       = anc_val;
        dep_rnode = anc_val;
        state_d   = S_Q_L1D;
      end
      S_Q_L1D: begin
        da_d = dep_val;
        if (lvl_q == '0) begin
          state_d = S_Q_EQ;
        end else begin
          lvl_d   = lvl_t'(lvl_q - 1'b1);
          state_d = S_Q_L1;
        end
      end
      S_Q_EQ: begin
        if (a_q == b_q) begin
          res_valid_d = 1'b1;
          res_d       = field_t'(a_q);
          state_d     = S_IDLE;
        end else begin
          lvl_d   = lvl_t'(LIFT_LEVELS - 1);
          state_d = S_Q_P2A;
        end
      end

      // Raise both nodes together while their ancestors differ.
      S_Q_P2A: begin
        anc_rnode = a_q;
        state_d   = S_Q_P2B;
      end
      S_Q_P2B: begin
        x_d       = anc_val;
        anc_rnode = b_q;
        state_d   = S_Q_P2C;
      end
      S_Q_P2C: begin
        if (x_q != anc_val) begin
          a_d = x_q;
          b_d = anc_val;
        end
        if (lvl_q == '0) begin
          // Fetch the parent of the final a.
          anc_rnode = (x_q != anc_val) ? x_q : a_q;
          anc_rlvl  = lvl_t'(0);
          state_d   = S_Q_FIN;
        end else begin
          lvl_d   = lvl_t'(lvl_q - 1'b1);
          state_d = S_Q_P2A;
        end
      end
      S_Q_FIN: begin
        res_valid_d = 1'b1;
        res_d       = field_t'(anc_val);
        state_d     = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= field_t'(1023);
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      node_count_q <= node_count_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    x_q      <= x_d;
    j_q      <= j_d;
    da_q     <= da_d;
    db_q     <= db_d;
    lvl_q    <= lvl_d;
    res_q    <= res_d;
    dep_rz_q <= (dep_rnode == '0);
    anc_rz_q <= (anc_rnode == '0);
  end

endmodule

`default_nettype wire

[rtl/tlbl_checker.sv]
// ----------------------------------------------------------------------------
// tlbl_checker: port-level checks for the LCA binary-lifting block
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbl_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] opcode_i,
  input wire logic       result_valid_o
);

  // A result appears only once the sequencer has returned to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // Two results never come in adjacent cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result strobes");

  // A load or query transfer always occupies the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == 2'd0 || opcode_i == 2'd2)) |=> busy)
    else $error("load or query did not start");

  // A result needs at least the two depth reads before it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(busy, 1) && $past(busy, 2)))
    else $error("result too early");

endmodule

bind tree_lca_binary_lifting_top tlbl_checker u_tlbl_checker (.*);

`default_nettype wire

[bench/tree_lca_binary_lifting_top_test.sv]
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting_top_test: self-checking bench for the LCA block
// Loads rooted trees node by node, sets node_count, builds the lifting table
// and fires ancestor queries. A bench-side model of the depth and ancestor
// tables predicts each answer not pinned by hand, and each answer strobe is compared with the
// oldest prediction. A short directed list runs first, then random trees.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_lca_binary_lifting_top_test;
  import tlbl_pkg::*;

  // Opcode 3 has no meaning in the block and must be swallowed silently.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // No new random tree starts once this many commands with an effect were accepted.
  localparam int RANDOM_ITEMS = 1100;

  // Quiet time after the last expected answer: a little over the slowest query.
  localparam int SETTLE_CYCLES = 5 + 6 * LIFT_LEVELS + 10;

  // A full build of 1023 nodes is the longest stretch without any transfer.
  localparam int WATCHDOG_LIMIT = 4 * 3 * LIFT_LEVELS * MAX_NODES;

  typedef bit [NODE_W-1:0] tree_node_t;

  typedef enum logic {
    ROW_CMD,
    ROW_CFG
  } row_kind_e;

  // One row of the directed list. A config row carries its value in node_a.
  typedef struct packed {
    row_kind_e  kind;
    logic [1:0] op;
    field_t     node_a;
    field_t     node_b;
    logic       pinned;
    field_t     want;
  } drill_row_t;

  typedef struct packed {
    field_t      anc;
    logic [31:0] seq;
  } lca_answer_t;

  // Port-side signals; the bench-driven inputs are at known values from time zero.
  logic   clk_i          = 1'b0;
  logic   rst_ni         = 1'b0;
  logic   start          = 1'b0;
  logic   busy;
  logic [1:0] opcode_i   = 2'd0;
  field_t node_a_i       = '0;
  field_t node_b_i       = '0;
  logic   result_valid_o;
  field_t ancestor_o;
  logic   cfg_valid_i    = 1'b0;
  logic   cfg_ready_o;
  field_t cfg_data_i     = '0;

  // Bench copy of the tree. The *_set arrays tell which entries have been
  // written since reset, so that no command ever reads an undefined entry.
  bit [DEP_W-1:0] depth_mem [MAX_NODES];
  tree_node_t     lift_mem  [MAX_NODES][LIFT_LEVELS];
  bit             depth_set [MAX_NODES];
  bit             lift_set  [MAX_NODES][LIFT_LEVELS];
  tree_node_t     scratch_lift [MAX_NODES][LIFT_LEVELS];
  bit             scratch_set  [MAX_NODES][LIFT_LEVELS];
  int unsigned    node_limit = 1023;

  lca_answer_t answer_q [$];
  lca_answer_t head;

  int errors      = 0;
  int checked     = 0;
  int quiet_count = 0;
  int idle_pct    = 0;
  int n_loads     = 0;
  int n_builds    = 0;
  int n_queries   = 0;
  int n_ignored   = 0;
  int n_cfg       = 0;
  int n_useful    = 0;
  int deepest     = 0;

  drill_row_t drills [24];

  tree_lca_binary_lifting_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .result_valid_o (result_valid_o),
    .ancestor_o     (ancestor_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Deepest common ancestor by binary lifting, on the bench copy of the tree.
  // Depth is looked up again for every node the walk lands on, as the block
  // does, so stale or looping tables after reloads are followed faithfully.
  // clean goes low if the walk touches an entry that was never written.
  function automatic tree_node_t lca_of(input tree_node_t a_in, input tree_node_t b_in,
                                        output bit clean);
    tree_node_t a;
    tree_node_t b;
    tree_node_t t;
    a = a_in;
    b = b_in;
    clean = depth_set[a] && depth_set[b];
    if (depth_mem[a] < depth_mem[b]) begin
      t = a;
      a = b;
      b = t;
    end
    for (int lvl = LIFT_LEVELS - 1; lvl >= 0; lvl--) begin
      clean &= depth_set[a];
      if (int'(depth_mem[a]) >= int'(depth_mem[b]) + (1 << lvl)) begin
        clean &= lift_set[a][lvl];
        a = lift_mem[a][lvl];
      end
    end
    if (a == b) begin
      return a;
    end
    for (int lvl = LIFT_LEVELS - 1; lvl >= 0; lvl--) begin
      clean &= lift_set[a][lvl] && lift_set[b][lvl];
      if (lift_mem[a][lvl] != lift_mem[b][lvl]) begin
        a = lift_mem[a][lvl];
        b = lift_mem[b][lvl];
      end
    end
    clean &= lift_set[a][0];
    return lift_mem[a][0];
  endfunction

  // Fills levels 1 and up for nodes 1..node_count, level by level, on a
  // scratch copy. Returns whether every read hit a written entry; the copy
  // replaces the bench tables only when commit is set.
  function automatic bit build_lifts(input bit commit);
    int         last;
    bit         clean;
    tree_node_t via;
    scratch_lift = lift_mem;
    scratch_set  = lift_set;
    clean = 1'b1;
    last = (node_limit > MAX_NODES - 1) ? MAX_NODES - 1 : int'(node_limit);
    for (int lvl = 1; lvl < LIFT_LEVELS; lvl++) begin
      for (int j = 1; j <= last; j++) begin
        via = scratch_lift[j][lvl-1];
        clean &= scratch_set[j][lvl-1] && scratch_set[via][lvl-1];
        scratch_lift[j][lvl] = scratch_lift[via][lvl-1];
        scratch_set[j][lvl]  = 1'b1;
      end
    end
    if (commit) begin
      lift_mem = scratch_lift;
      lift_set = scratch_set;
    end
    return clean;
  endfunction

  // Draws a query pair, mostly among the nodes of the current tree and now
  // and then anywhere, keeping only pairs whose walk reads written entries.
  function automatic void pick_pair(input int span, output field_t qa, output field_t qb);
    bit clean;
    for (int t = 0; t < 8; t++) begin
      qa = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_NODES - 1) : $urandom_range(0, span);
      qb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_NODES - 1) : $urandom_range(0, span);
      void'(lca_of(qa, qb, clean));
      if (clean) begin
        return;
      end
    end
    qa = '0;
    qb = '0;
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Presents one command and holds it until the block takes it (start high,
  // busy low at a rising edge). The bench model is updated at that edge.
  // start stays high on return, so a following command goes back to back.
  task automatic issue(input logic [1:0] op, input field_t a, input field_t b,
                       input bit pinned, input field_t pinned_val);
    tree_node_t  na;
    tree_node_t  nb;
    int unsigned d;
    bit          clean;
    lca_answer_t ans;
    start    <= 1'b1;
    opcode_i <= op;
    node_a_i <= a;
    node_b_i <= b;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    // Node numbers beyond the table collapse onto the virtual node 0.
    na = (int'(a) < MAX_NODES) ? tree_node_t'(a) : '0;
    nb = (int'(b) < MAX_NODES) ? tree_node_t'(b) : '0;
    case (op)
      OP_LOAD: begin
        // Loading node 0 is dropped, so the virtual root never moves.
        if (na != 0) begin
          d = depth_mem[nb] + 1;
          if (d > DEPTH_MAX) begin
            d = DEPTH_MAX;
          end
          depth_mem[na]   = d[DEP_W-1:0];
          depth_set[na]   = 1'b1;
          lift_mem[na][0] = nb;
          lift_set[na][0] = 1'b1;
          if (int'(d) > deepest) begin
            deepest = d;
          end
          n_loads++;
          n_useful++;
        end else begin
          n_ignored++;
        end
      end
      OP_BUILD: begin
        void'(build_lifts(1'b1));
        n_builds++;
        n_useful++;
      end
      OP_QUERY: begin
        ans.anc = lca_of(na, nb, clean);
        if (pinned) begin
          ans.anc = pinned_val;
        end
        ans.seq = n_queries;
        answer_q.push_back(ans);
        n_queries++;
        n_useful++;
      end
      default: begin
        n_ignored++;
      end
    endcase
  endtask

  // Random sender gaps. Most are short so they land on every step of a load
  // or a query; a few are long enough to leave the block idle.
  task automatic sender_gap();
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 80) : $urandom_range(1, 4)) begin
        @(posedge clk_i);
      end
    end
  endtask

  // Holds the sender off until every predicted answer has come back and the
  // block has dropped busy, then leaves a short quiet stretch. Used before
  // each node_count write, as back-pressure inside an epoch, and at the end.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (answer_q.size() != 0 || busy) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_node_count(input field_t value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    node_limit = value;
    n_cfg++;
  endtask

  // Commands the block should shrug off, mixed with an off-pattern query.
  task automatic stray_item(input int span);
    field_t qa;
    field_t qb;
    case ($urandom_range(0, 2))
      0: issue(OP_UNUSED, $urandom_range(0, MAX_NODES - 1), $urandom_range(0, MAX_NODES - 1), 1'b0, '0);
      1: issue(OP_LOAD, '0, $urandom_range(0, MAX_NODES - 1), 1'b0, '0);
      default: begin
        pick_pair(span, qa, qb);
        issue(OP_QUERY, qa, qb, 1'b0, '0);
      end
    endcase
  endtask

  // One random tree: load nodes 1..n parent first, set node_count, build,
  // then a burst of queries with reloads, rebuilds and noise mixed in.
  // The full-size tree is a single chain, so its deepest node sits at the
  // saturated depth, and a node reloaded under it has to saturate as well.
  task automatic run_epoch(input bit full_size);
    int     n_nodes;
    int     style;
    int     n_asks;
    int     pick;
    int     n;
    field_t par;
    field_t qa;
    field_t qb;
    n_nodes = full_size ? MAX_NODES - 1 : $urandom_range(1, 48);
    style   = full_size ? 0 : $urandom_range(0, 2);
    for (int k = 1; k <= n_nodes; k++) begin
      case (style)
        0: par = (full_size || $urandom_range(0, 4) != 0) ? k - 1 : $urandom_range(0, k - 1);
        1: par = $urandom_range(0, k - 1);
        default: par = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range((k > 4) ? k - 4 : 0, k - 1);
      endcase
      sender_gap();
      issue(OP_LOAD, k, par, 1'b0, '0);
      if ($urandom_range(0, 24) == 0) begin
        sender_gap();
        stray_item(n_nodes);
      end
    end

    if (full_size) begin
      write_node_count(MAX_NODES - 1);
    end else begin
      write_node_count(($urandom_range(0, 9) < 7) ? n_nodes : $urandom_range(0, n_nodes));
    end
    sender_gap();
    issue(OP_BUILD, '0, '0, 1'b0, '0);

    n_asks = full_size ? 60 : $urandom_range(10, 40);
    for (int k = 0; k < n_asks; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        settle();
      end
      sender_gap();
      if (full_size && k == n_asks / 2) begin
        // Hang a node under the deepest one: its depth clamps at the top, and
        // the rebuilt table now loops through the chain.
        issue(OP_LOAD, $urandom_range(1, MAX_NODES - 2), MAX_NODES - 1, 1'b0, '0);
        sender_gap();
        issue(OP_BUILD, '0, '0, 1'b0, '0);
        continue;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // Reload under any already placed node; parents may now sit below.
        n   = $urandom_range(1, n_nodes);
        par = $urandom_range(0, MAX_NODES - 1);
        if (!depth_set[par]) begin
          par = $urandom_range(0, n - 1);
        end
        issue(OP_LOAD, n, par, 1'b0, '0);
      end else if (pick < 6 && build_lifts(1'b0)) begin
        issue(OP_BUILD, '0, '0, 1'b0, '0);
      end else if (pick < 9) begin
        stray_item(n_nodes);
      end else begin
        pick_pair(n_nodes, qa, qb);
        issue(OP_QUERY, qa, qb, 1'b0, '0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_fault(input string what);
    errors++;
    if (errors <= 10) begin
      $display("Mismatch %0d at %0t: %s", errors, $time, what);
    end
  endtask

  // The strobe lasts one cycle and cannot be held off, so every strobe seen
  // at a rising edge is one answer transfer.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (answer_q.size() == 0) begin
        report_fault($sformatf("answer %0d arrived with no query pending", ancestor_o));
      end else begin
        head = answer_q.pop_front();
        checked++;
        if (ancestor_o !== head.anc) begin
          report_fault($sformatf("query %0d: ancestor expected %0d, got %0d",
                                 head.seq, head.anc, ancestor_o));
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which no transfer of any kind happens.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d answers outstanding",
               quiet_count, answer_q.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------

  initial begin
    // Virtual node 0 sits at depth 0 with all ancestors 0 from reset onward.
    depth_set[0] = 1'b1;
    for (int lvl = 0; lvl < LIFT_LEVELS; lvl++) begin
      lift_set[0][lvl] = 1'b1;
    end

    // Directed list. Expected answers are typed in only where they are plain
    // (the virtual root, separate roots); the rest come from the model.
    // Tree: 1 and 7 are roots, 2 and 3 under 1, 4 and 5 under 2, 6 under 3.
    drills = '{
      '{ROW_CMD, OP_QUERY,  10'd0,    10'd0,    1'b1, 10'd0}, // fresh reset
      '{ROW_CMD, OP_UNUSED, 10'd1023, 10'd1023, 1'b0, 10'd0}, // ignored
      '{ROW_CMD, OP_LOAD,   10'd0,    10'd1023, 1'b0, 10'd0}, // node 0 fixed
      '{ROW_CMD, OP_LOAD,   10'd1,    10'd0,    1'b0, 10'd0},
      '{ROW_CMD, OP_LOAD,   10'd2,    10'd1,    1'b0, 10'd0},
      '{ROW_CMD, OP_LOAD,   10'd3,    10'd1,    1'b0, 10'd0},
      '{ROW_CMD, OP_LOAD,   10'd4,    10'd2,    1'b0, 10'd0},
      '{ROW_CMD, OP_LOAD,   10'd5,    10'd2,    1'b0, 10'd0},
      '{ROW_CMD, OP_LOAD,   10'd6,    10'd3,    1'b0, 10'd0},
      '{ROW_CMD, OP_LOAD,   10'd7,    10'd0,    1'b0, 10'd0},
      '{ROW_CFG, OP_LOAD,   10'd7,    10'd0,    1'b0, 10'd0},
      '{ROW_CMD, OP_BUILD,  10'd0,    10'd0,    1'b0, 10'd0},
      '{ROW_CMD, OP_QUERY,  10'd4,    10'd5,    1'b0, 10'd0},
      '{ROW_CMD, OP_QUERY,  10'd4,    10'd6,    1'b0, 10'd0},
      '{ROW_CMD, OP_QUERY,  10'd5,    10'd5,    1'b0, 10'd0},
      '{ROW_CMD, OP_QUERY,  10'd1,    10'd4,    1'b0, 10'd0},
      '{ROW_CMD, OP_QUERY,  10'd6,    10'd0,    1'b1, 10'd0}, // against node 0
      '{ROW_CMD, OP_QUERY,  10'd7,    10'd4,    1'b1, 10'd0}, // separate roots
      '{ROW_CFG, OP_LOAD,   10'd0,    10'd0,    1'b0, 10'd0}, // build is a no-op
      '{ROW_CMD, OP_BUILD,  10'd0,    10'd0,    1'b0, 10'd0},
      '{ROW_CMD, OP_QUERY,  10'd4,    10'd6,    1'b0, 10'd0},
      '{ROW_CFG, OP_LOAD,   10'd1,    10'd0,    1'b0, 10'd0}, // smallest range
      '{ROW_CMD, OP_BUILD,  10'd0,    10'd0,    1'b0, 10'd0},
      '{ROW_CMD, OP_QUERY,  10'd3,    10'd7,    1'b0, 10'd0}
    };

    repeat (5) begin
      @(posedge clk_i);
    end
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (drills[i]) begin
      if (drills[i].kind == ROW_CFG) begin
        write_node_count(drills[i].node_a);
      end else begin
        issue(drills[i].op, drills[i].node_a, drills[i].node_b, drills[i].pinned, drills[i].want);
      end
    end

    // Random trees. The sender's idle rate rotates through none, heavy and
    // light; the fifth tree is the full-size chain.
    n_useful = 0;
    for (int epoch = 0; n_useful < RANDOM_ITEMS; epoch++) begin
      idle_pct = (epoch % 3 == 1) ? 62 : ((epoch % 3 == 2) ? 19 : 0);
      run_epoch(epoch == 4);
    end

    settle();

    $display("Run covered %0d loads, %0d builds, %0d queries, %0d ignored commands, %0d node_count writes.",
             n_loads, n_builds, n_queries, n_ignored, n_cfg);
    $display("%0d answers compared, deepest node depth %0d, %0d mismatches.",
             checked, deepest, errors);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
